>>> design/ngga_pkg.sv
`default_nettype none

package ngga_pkg;

    // field phase codes, counted up by commas
    localparam logic [4:0] PH_IDLE     = 5'd0;
    localparam logic [4:0] PH_TYPE     = 5'd1;
    localparam logic [4:0] PH_TIME     = 5'd2;
    localparam logic [4:0] PH_LAT      = 5'd3;
    localparam logic [4:0] PH_LAT_DIR  = 5'd4;
    localparam logic [4:0] PH_LON      = 5'd5;
    localparam logic [4:0] PH_LON_DIR  = 5'd6;
    localparam logic [4:0] PH_QUAL     = 5'd7;
    localparam logic [4:0] PH_SATS     = 5'd8;
    localparam logic [4:0] PH_ALT      = 5'd10;
    localparam logic [4:0] PH_ALT_UNIT = 5'd11;
    localparam logic [4:0] PH_CHECK    = 5'd16;
    localparam logic [4:0] PH_STOP     = 5'd17;
    localparam logic [4:0] PH_MAX      = 5'd31;

    // characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // sentence type, first character in element 0
    localparam logic [4:0][7:0] GGA_TYPE = {8'h41, 8'h47, 8'h47, 8'h50, 8'h47};

    // result kinds
    localparam logic [2:0] KIND_TIME = 3'd0;
    localparam logic [2:0] KIND_LAT  = 3'd1;
    localparam logic [2:0] KIND_LON  = 3'd2;
    localparam logic [2:0] KIND_INFO = 3'd3;
    localparam logic [2:0] KIND_ALT  = 3'd4;

    localparam logic [7:0] DIV_BY = 8'd100;

    // reciprocal of one hundred scaled by 2^37, exact for any 32-bit dividend
    localparam logic [31:0] DIV_MUL = 32'h51EB851F;

    // single characters and stamp of one finished sentence
    typedef struct packed {
        logic [7:0]  lat_dir;
        logic [7:0]  lon_dir;
        logic [7:0]  qual;
        logic [7:0]  alt_unit;
        logic [7:0]  sat0;
        logic [7:0]  sat1;
        logic [31:0] stamp;
    } t_job_misc;

    // back end status toward the top level
    typedef struct packed {
        logic idle;
    } t_back_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PARSE,
        BK_SCALE,
        BK_DIV,
        BK_EMIT
    } t_bk_state;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
        else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
        else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

>>> design/ngga_front.sv
`default_nettype none

module ngga_front #(
    parameter int FIELD_CHARS = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [7:0]                    i_rx_byte,
    input  wire logic [31:0]                   i_time_ms,
    output logic                               o_job_valid,
    input  wire logic                          i_job_take,
    output logic [FIELD_CHARS-1:0][7:0]        o_job_time,
    output logic [FIELD_CHARS-1:0][7:0]        o_job_lat,
    output logic [FIELD_CHARS-1:0][7:0]        o_job_lon,
    output logic [FIELD_CHARS-1:0][7:0]        o_job_alt,
    output ngga_pkg::t_job_misc                o_job_misc
);
    import ngga_pkg::*;

    localparam int IW = $clog2(FIELD_CHARS + 1);

    logic [4:0]                   r_phase, n_phase;
    logic [7:0]                   r_xor, n_xor;
    logic [IW-1:0]                r_idx, n_idx;
    logic [4:0][7:0]              r_type, n_type;
    logic [FIELD_CHARS-1:0][7:0]  r_time, n_time, r_lat, n_lat;
    logic [FIELD_CHARS-1:0][7:0]  r_lon, n_lon, r_alt, n_alt;
    logic [3:0][7:0]              r_single, n_single;
    logic [1:0][7:0]              r_sat, n_sat, r_chk, n_chk;

    // one-entry job queue toward the back end
    logic                         r_jv, n_jv;
    logic [FIELD_CHARS-1:0][7:0]  r_jtime, n_jtime, r_jlat, n_jlat;
    logic [FIELD_CHARS-1:0][7:0]  r_jlon, n_jlon, r_jalt, n_jalt;
    t_job_misc                    r_jmisc, n_jmisc;

    logic       acc;
    logic [7:0] c;
    logic       fit_f, fit5, fit2;
    logic [7:0] want;

    assign full = r_jv;
    assign acc  = push && !r_jv;
    assign c    = i_rx_byte;
    assign fit_f = r_idx < IW'(FIELD_CHARS);
    assign fit5  = r_idx < IW'(5);
    assign fit2  = r_idx < IW'(2);
    assign want  = {hex_val(r_chk[0]), hex_val(r_chk[1])};

    // byte classification and field capture
    always_comb begin
        n_phase = r_phase; n_xor = r_xor; n_idx = r_idx; n_type = r_type;
        n_time = r_time; n_lat = r_lat; n_lon = r_lon; n_alt = r_alt;
        n_single = r_single; n_sat = r_sat; n_chk = r_chk;
        n_jv = r_jv && !i_job_take;
        n_jtime = r_jtime; n_jlat = r_jlat; n_jlon = r_jlon; n_jalt = r_jalt;
        n_jmisc = r_jmisc;
        if (acc) begin
            priority if (c == CH_DOLLAR) begin
                n_phase = PH_TYPE; n_xor = '0; n_idx = '0; n_type = '0;
                n_time = '0; n_lat = '0; n_lon = '0; n_alt = '0;
                n_single = '0; n_sat = '0; n_chk = '0;
            end else if (c == CH_COMMA) begin
                if (r_phase != PH_IDLE) begin
                    if (r_phase == PH_TYPE && r_type != GGA_TYPE) begin
                        n_phase = PH_STOP;
                    end else begin
                        if (r_phase < PH_MAX) n_phase = r_phase + 5'd1;
                        n_idx = '0;
                        n_xor = r_xor ^ c;
                    end
                end
            end else if (c == CH_STAR) begin
                if (r_phase != PH_IDLE) begin
                    n_phase = PH_CHECK;
                    n_idx   = '0;
                end
            end else if (c == CH_CR || c == CH_LF) begin
                if (r_phase == PH_CHECK && want == r_xor) begin
                    n_jv = 1'b1;
                    n_jtime = r_time; n_jlat = r_lat; n_jlon = r_lon; n_jalt = r_alt;
                    n_jmisc.lat_dir  = r_single[0];
                    n_jmisc.lon_dir  = r_single[1];
                    n_jmisc.qual     = r_single[2];
                    n_jmisc.alt_unit = r_single[3];
                    n_jmisc.sat0     = r_sat[0];
                    n_jmisc.sat1     = r_sat[1];
                    n_jmisc.stamp    = i_time_ms;
                end
                n_phase = PH_STOP;
            end else begin
                unique case (r_phase)
                    PH_IDLE: ;
                    PH_TYPE: if (fit5) begin
                        for (int k = 0; k < 5; k++) if (r_idx == IW'(k)) n_type[k] = c;
                        n_idx = r_idx + IW'(1);
                    end
                    PH_TIME: if (fit_f) begin
                        for (int k = 0; k < FIELD_CHARS; k++)
                            if (r_idx == IW'(k)) n_time[k] = c;
                        n_idx = r_idx + IW'(1);
                    end
                    PH_LAT: if (fit_f) begin
                        for (int k = 0; k < FIELD_CHARS; k++)
                            if (r_idx == IW'(k)) n_lat[k] = c;
                        n_idx = r_idx + IW'(1);
                    end
                    PH_LON: if (fit_f) begin
                        for (int k = 0; k < FIELD_CHARS; k++)
                            if (r_idx == IW'(k)) n_lon[k] = c;
                        n_idx = r_idx + IW'(1);
                    end
                    PH_ALT: if (fit_f) begin
                        for (int k = 0; k < FIELD_CHARS; k++)
                            if (r_idx == IW'(k)) n_alt[k] = c;
                        n_idx = r_idx + IW'(1);
                    end
                    PH_SATS: if (fit2) begin
                        for (int k = 0; k < 2; k++) if (r_idx == IW'(k)) n_sat[k] = c;
                        n_idx = r_idx + IW'(1);
                    end
                    PH_CHECK: if (fit2) begin
                        for (int k = 0; k < 2; k++) if (r_idx == IW'(k)) n_chk[k] = c;
                        n_idx = r_idx + IW'(1);
                    end
                    PH_LAT_DIR:  n_single[0] = c;
                    PH_LON_DIR:  n_single[1] = c;
                    PH_QUAL:     n_single[2] = c;
                    PH_ALT_UNIT: n_single[3] = c;
                    default: if (r_phase >= PH_STOP) n_phase = PH_IDLE;
                endcase
                if (r_phase != PH_CHECK) n_xor = r_xor ^ c;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_xor <= '0; r_idx <= '0; r_type <= '0;
            r_time <= '0; r_lat <= '0; r_lon <= '0; r_alt <= '0;
            r_single <= '0; r_sat <= '0; r_chk <= '0; r_jv <= 1'b0;
        end else begin
            r_phase <= n_phase; r_xor <= n_xor; r_idx <= n_idx; r_type <= n_type;
            r_time <= n_time; r_lat <= n_lat; r_lon <= n_lon; r_alt <= n_alt;
            r_single <= n_single; r_sat <= n_sat; r_chk <= n_chk; r_jv <= n_jv;
        end
    end

    // job payload
    always_ff @(posedge i_clk) begin
        r_jtime <= n_jtime; r_jlat <= n_jlat; r_jlon <= n_jlon; r_jalt <= n_jalt;
        r_jmisc <= n_jmisc;
    end

    assign o_job_valid = r_jv;
    assign o_job_time  = r_jtime;
    assign o_job_lat   = r_jlat;
    assign o_job_lon   = r_jlon;
    assign o_job_alt   = r_jalt;
    assign o_job_misc  = r_jmisc;

endmodule

`default_nettype wire

>>> design/ngga_back.sv
`default_nettype none

module ngga_back #(
    parameter int FIELD_CHARS = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_job_valid,
    output logic                               o_job_take,
    input  wire logic [FIELD_CHARS-1:0][7:0]   i_job_time,
    input  wire logic [FIELD_CHARS-1:0][7:0]   i_job_lat,
    input  wire logic [FIELD_CHARS-1:0][7:0]   i_job_lon,
    input  wire logic [FIELD_CHARS-1:0][7:0]   i_job_alt,
    input  wire ngga_pkg::t_job_misc           i_job_misc,
    output ngga_pkg::t_back_status             o_status,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [2:0]                         o_kind,
    output logic [15:0]                        o_value_a,
    output logic [7:0]                         o_value_b,
    output logic [13:0]                        o_value_c,
    output logic [6:0]                         o_value_d,
    output logic [7:0]                         o_direction,
    output logic [31:0]                        o_stamp_ms,
    output logic                               o_last
);
    import ngga_pkg::*;

    localparam int IW = $clog2(FIELD_CHARS + 1);

    t_bk_state r_state, n_state;

    logic [2:0]                   r_kind, n_kind;
    logic [1:0]                   r_sub, n_sub;
    logic [FIELD_CHARS-1:0][7:0]  r_lat, n_lat, r_lon, n_lon, r_alt, n_alt;
    t_job_misc                    r_misc, n_misc;
    logic [FIELD_CHARS-1:0][7:0]  r_sh, n_sh;
    logic [IW-1:0]                r_pcnt, n_pcnt;
    logic                         r_frac, n_frac, r_pstop, n_pstop;
    logic [2:0]                   r_nfrac, n_nfrac;
    logic [31:0]                  r_w, n_w;
    logic [13:0]                  r_f, n_f;
    logic [31:0]                  r_dnum, n_dnum;
    logic [63:0]                  r_prod, n_prod;
    logic                         r_dcnt, n_dcnt;
    logic [15:0]                  r_a, n_a;
    logic [7:0]                   r_b, n_b;
    logic [13:0]                  r_c, n_c;
    logic [6:0]                   r_d, n_d;

    logic                         r_ov, n_ov;
    logic [2:0]                   r_okind, n_okind;
    logic [15:0]                  r_oa, n_oa;
    logic [7:0]                   r_ob, n_ob, r_odir, n_odir;
    logic [13:0]                  r_oc, n_oc;
    logic [6:0]                   r_od, n_od;
    logic [31:0]                  r_ostamp, n_ostamp;
    logic                         r_olast, n_olast;

    logic [7:0]  ch;
    logic [3:0]  dg;
    logic        dv_last, div_done, out_free, parse_end;
    logic [6:0]  dv_rem;
    logic [31:0] dv_q;
    logic [15:0] sats;
    logic [7:0]  odir;

    assign ch        = r_sh[0];
    assign dg        = 4'(ch - CH_ZERO);
    assign parse_end = r_pcnt == IW'(FIELD_CHARS - 1);

    // divide by one hundred: registered reciprocal product, then quotient and remainder
    assign dv_q     = {5'd0, r_prod[63:37]};
    assign dv_rem   = 7'(r_dnum - dv_q * 32'(DIV_BY));
    assign dv_last  = r_dcnt;
    assign div_done = dv_last && (r_kind != KIND_TIME || r_sub == 2'd3);
    assign out_free = !r_ov || pop;

    // satellite count, up to two digits
    always_comb begin
        sats = 16'd0;
        if (is_digit(r_misc.sat0)) begin
            sats = 16'(r_misc.sat0 - CH_ZERO);
            if (is_digit(r_misc.sat1)) sats = 16'(sats * 16'd10 + 16'(r_misc.sat1 - CH_ZERO));
        end
    end

    // direction character per kind
    always_comb begin
        unique case (r_kind)
            KIND_LAT: odir = r_misc.lat_dir;
            KIND_LON: odir = r_misc.lon_dir;
            KIND_ALT: odir = r_misc.alt_unit;
            default:  odir = 8'd0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:  if (i_job_valid) n_state = BK_PARSE;
            BK_PARSE: if (parse_end) n_state = BK_SCALE;
            BK_SCALE: if (r_nfrac == 3'd4) n_state = BK_DIV;
            BK_DIV:   if (div_done) n_state = BK_EMIT;
            BK_EMIT: if (out_free) begin
                if (r_kind == KIND_ALT) n_state = BK_IDLE;
                else if (r_kind == KIND_LON) n_state = BK_EMIT;
                else n_state = BK_PARSE;
            end
            default:  n_state = BK_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_kind = r_kind; n_sub = r_sub; n_lat = r_lat; n_lon = r_lon; n_alt = r_alt;
        n_misc = r_misc; n_sh = r_sh; n_pcnt = r_pcnt; n_frac = r_frac;
        n_pstop = r_pstop; n_nfrac = r_nfrac; n_w = r_w; n_f = r_f;
        n_dnum = r_dnum; n_prod = r_prod; n_dcnt = r_dcnt;
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d;
        n_ov = r_ov && !pop;
        n_okind = r_okind; n_oa = r_oa; n_ob = r_ob; n_oc = r_oc; n_od = r_od;
        n_odir = r_odir; n_ostamp = r_ostamp; n_olast = r_olast;
        o_job_take = 1'b0;
        unique case (r_state)
            BK_IDLE: if (i_job_valid) begin
                o_job_take = 1'b1;
                n_lat = i_job_lat; n_lon = i_job_lon; n_alt = i_job_alt;
                n_misc = i_job_misc; n_sh = i_job_time; n_kind = KIND_TIME;
                n_pcnt = '0; n_frac = 1'b0; n_pstop = 1'b0; n_nfrac = '0;
                n_w = '0; n_f = '0; n_a = '0; n_b = '0; n_c = '0; n_d = '0;
            end
            BK_PARSE: begin
                n_sh = r_sh >> 8;
                n_pcnt = r_pcnt + IW'(1);
                if (!r_pstop) begin
                    if (!r_frac) begin
                        if (is_digit(ch)) n_w = (r_w << 3) + (r_w << 1) + 32'(dg);
                        else if (ch == CH_DOT) n_frac = 1'b1;
                        else n_pstop = 1'b1;
                    end else if (is_digit(ch) && r_nfrac != 3'd4) begin
                        n_f = 14'((r_f << 3) + (r_f << 1) + 14'(dg));
                        n_nfrac = r_nfrac + 3'd1;
                    end else begin
                        n_pstop = 1'b1;
                    end
                end
            end
            BK_SCALE: begin
                if (r_nfrac != 3'd4) begin
                    n_f = 14'((r_f << 3) + (r_f << 1));
                    n_nfrac = r_nfrac + 3'd1;
                end else begin
                    n_sub = 2'd0; n_dcnt = 1'b0;
                    n_dnum = (r_kind == KIND_ALT) ? 32'(r_f) : r_w;
                end
            end
            BK_DIV: begin
                n_dcnt = !r_dcnt;
                if (!r_dcnt) begin
                    n_prod = {32'd0, r_dnum} * {32'd0, DIV_MUL};
                end else begin
                    n_dnum = dv_q; n_sub = r_sub + 2'd1;
                    unique case (r_kind)
                        KIND_TIME: begin
                            unique case (r_sub)
                                2'd0: n_c = 14'(dv_rem);
                                2'd1: n_b = 8'(dv_rem);
                                2'd2: begin
                                    n_a = 16'(dv_rem);
                                    n_dnum = 32'(r_f);
                                end
                                default: n_d = dv_q[6:0];
                            endcase
                        end
                        KIND_LAT, KIND_LON: begin
                            n_a = 16'(dv_q[7:0]); n_b = 8'(dv_rem); n_c = r_f;
                        end
                        default: begin
                            n_a = r_w[15:0]; n_d = dv_q[6:0];
                        end
                    endcase
                end
            end
            BK_EMIT: if (out_free) begin
                n_ov = 1'b1; n_okind = r_kind; n_oa = r_a; n_ob = r_b; n_oc = r_c;
                n_od = r_d; n_odir = odir; n_ostamp = r_misc.stamp;
                n_olast = r_kind == KIND_ALT;
                n_kind = r_kind + 3'd1;
                n_pcnt = '0; n_frac = 1'b0; n_pstop = 1'b0; n_nfrac = '0;
                n_w = '0; n_f = '0; n_a = '0; n_b = '0; n_c = '0; n_d = '0;
                unique case (r_kind)
                    KIND_TIME: n_sh = r_lat;
                    KIND_LAT:  n_sh = r_lon;
                    KIND_LON: begin
                        n_a = sats;
                        n_b = r_misc.qual - CH_ZERO;
                    end
                    default:   n_sh = r_alt;
                endcase
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind; r_sub <= n_sub; r_lat <= n_lat; r_lon <= n_lon;
        r_alt <= n_alt; r_misc <= n_misc; r_sh <= n_sh; r_pcnt <= n_pcnt;
        r_frac <= n_frac; r_pstop <= n_pstop; r_nfrac <= n_nfrac;
        r_w <= n_w; r_f <= n_f; r_dnum <= n_dnum; r_prod <= n_prod;
        r_dcnt <= n_dcnt; r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d;
        r_okind <= n_okind; r_oa <= n_oa; r_ob <= n_ob; r_oc <= n_oc;
        r_od <= n_od; r_odir <= n_odir; r_ostamp <= n_ostamp; r_olast <= n_olast;
    end

    assign o_status.idle = r_state == BK_IDLE;
    assign empty       = !r_ov;
    assign o_kind      = r_okind;
    assign o_value_a   = r_oa;
    assign o_value_b   = r_ob;
    assign o_value_c   = r_oc;
    assign o_value_d   = r_od;
    assign o_direction = r_odir;
    assign o_stamp_ms  = r_ostamp;
    assign o_last      = r_olast;

endmodule

`default_nettype wire

>>> design/nmea_gga_sentence_parser.sv
// results: a checked line end yields five results; a decimal field is parsed character
// by character, its fraction is scaled to four digits, and it is then divided by one
// hundred with a reciprocal multiply whose product is registered
// throughput: one byte per cycle while full is low; full stays high while a job is
// queued, until the back end takes it
// reset: synchronous active-low i_rst_n clears parser state, queue and output register
`default_nettype none

module nmea_gga_sentence_parser #(
    parameter int FIELD_CHARS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [31:0] i_time_ms,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_kind,
    output logic [15:0]      o_value_a,
    output logic [7:0]       o_value_b,
    output logic [13:0]      o_value_c,
    output logic [6:0]       o_value_d,
    output logic [7:0]       o_direction,
    output logic [31:0]      o_stamp_ms,
    output logic             o_last
);
    import ngga_pkg::*;

    logic                         job_valid, job_take;
    logic [FIELD_CHARS-1:0][7:0]  job_time, job_lat, job_lon, job_alt;
    t_job_misc                    job_misc;
    t_back_status                 bk_status;

    // byte capture and checksum
    ngga_front #(.FIELD_CHARS(FIELD_CHARS)) u_front (
        .i_clk, .i_rst_n, .push, .full, .i_rx_byte, .i_time_ms,
        .o_job_valid(job_valid), .i_job_take(job_take),
        .o_job_time(job_time), .o_job_lat(job_lat), .o_job_lon(job_lon),
        .o_job_alt(job_alt), .o_job_misc(job_misc)
    );

    // conversion and result delivery
    ngga_back #(.FIELD_CHARS(FIELD_CHARS)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .o_job_take(job_take),
        .i_job_time(job_time), .i_job_lat(job_lat), .i_job_lon(job_lon),
        .i_job_alt(job_alt), .i_job_misc(job_misc), .o_status(bk_status),
        .empty, .pop, .o_kind, .o_value_a, .o_value_b, .o_value_c, .o_value_d,
        .o_direction, .o_stamp_ms, .o_last
    );

`ifndef NO_ASSERTIONS
    // an idle back end takes a queued job, so the job queue is empty in the next cycle
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_valid && bk_status.idle |=> !job_valid)
        else $error("job not taken by idle back end");

    // only the altitude result ends a run
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last == (o_kind == KIND_ALT)))
        else $error("last flag does not match kind");

    // no result kind beyond altitude
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_kind <= KIND_ALT))
        else $error("result kind out of range");
`endif

endmodule

`default_nettype wire
